// File: hdl/cls_pkg.sv
`timescale 1ns / 1ps
// shared sizes, codes and command/status types of the circular list store
package cls_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // request kinds
    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_DELETE   = 2'd1;
    localparam logic [1:0] ACT_TRAVERSE = 2'd2;
    localparam logic [1:0] ACT_CLEAR    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_ENTRY    = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    // result data source
    localparam logic [1:0] SEL_IN  = 2'd0;
    localparam logic [1:0] SEL_VAL = 2'd1;
    localparam logic [1:0] SEL_MEM = 2'd2;

    typedef struct packed {
        logic       pos_clr;
        logic       pos_inc;
        logic       cap_value;
        logic       do_insert;
        logic       do_clear;
        logic       dec_count;
        logic       shift_wr;
        logic       load_res;
        logic [2:0] res_status;
        logic       res_last;
        logic [1:0] res_sel;
    } cls_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic at_last;
        logic out_free;
    } cls_sts_t;

    // front plus offset, wrapped into the ring
    function automatic logic [IDX_W-1:0] slot_wrap(input logic [IDX_W:0] sum);
        logic [IDX_W:0] cap;
        cap = (IDX_W + 1)'(CAPACITY);
        if (sum >= cap) begin
            slot_wrap = IDX_W'(sum - cap);
        end else begin
            slot_wrap = IDX_W'(sum);
        end
    endfunction

endpackage

// File: hdl/cls_ctrl.sv
`timescale 1ns / 1ps
// request sequencer of the circular list store
module cls_ctrl
    import cls_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] action,
    input  cls_sts_t   sts,
    output cls_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SRCH  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_TRAV  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == S_IDLE) && sts.out_free;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                cmd.pos_clr  = 1'b1;
                cmd.res_sel  = SEL_IN;
                cmd.res_last = 1'b1;
                if (s_tvalid && s_tready) begin
                    cmd.cap_value = 1'b1;
                    case (action)
                        ACT_INSERT: begin
                            cmd.load_res = 1'b1;
                            if (sts.full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.do_insert  = 1'b1;
                                cmd.res_status = ST_INSERTED;
                            end
                        end
                        ACT_DELETE: begin
                            if (sts.empty) begin
                                cmd.load_res   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                state_next = S_SRCH;
                            end
                        end
                        ACT_TRAVERSE: begin
                            if (sts.empty) begin
                                cmd.load_res   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                state_next = S_TRAV;
                            end
                        end
                        default: begin
                            cmd.do_clear   = 1'b1;
                            cmd.load_res   = 1'b1;
                            cmd.res_status = ST_CLEARED;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                cmd.res_sel  = SEL_VAL;
                cmd.res_last = 1'b1;
                if (sts.match) begin
                    if (sts.at_last) begin
                        // match on the tail entry, nothing to close up
                        if (sts.out_free) begin
                            cmd.dec_count  = 1'b1;
                            cmd.load_res   = 1'b1;
                            cmd.res_status = ST_REMOVED;
                            state_next     = S_IDLE;
                        end
                    end else begin
                        cmd.pos_inc = 1'b1;
                        state_next  = S_SHIFT;
                    end
                end else if (sts.at_last) begin
                    if (sts.out_free) begin
                        cmd.load_res   = 1'b1;
                        cmd.res_status = ST_NOTFOUND;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.pos_inc = 1'b1;
                end
            end
            S_SHIFT: begin
                // move entry pos down to pos-1, a repeat while stalled is harmless
                cmd.shift_wr = 1'b1;
                cmd.res_sel  = SEL_VAL;
                cmd.res_last = 1'b1;
                if (sts.at_last) begin
                    if (sts.out_free) begin
                        cmd.dec_count  = 1'b1;
                        cmd.load_res   = 1'b1;
                        cmd.res_status = ST_REMOVED;
                        state_next     = S_IDLE;
                    end
                end else begin
                    cmd.pos_inc = 1'b1;
                end
            end
            S_TRAV: begin
                cmd.res_sel    = SEL_MEM;
                cmd.res_status = ST_ENTRY;
                cmd.res_last   = sts.at_last;
                if (sts.out_free) begin
                    cmd.load_res = 1'b1;
                    if (sts.at_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.pos_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/cls_dp.sv
`timescale 1ns / 1ps
// entry ring, count and front pointer, walk position and result register
module cls_dp
    import cls_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [DATA_W-1:0] in_value,
    input  cls_cmd_t                 cmd,
    output cls_sts_t                 sts,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,
    output logic [2:0]               m_tuser,
    output logic                     m_tlast
);

    logic [DATA_W-1:0] mem [CAPACITY];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  front_reg;
    logic [IDX_W-1:0]  front_next;
    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  pos_next;
    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [2:0]        out_status_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  front_dec;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W:0]    prev_sum;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] res_data;

    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;

    always_comb begin
        if (cmd.pos_clr) begin
            pos_next = '0;
        end else if (cmd.pos_inc) begin
            pos_next = pos_reg + 1'b1;
        end else begin
            pos_next = pos_reg;
        end
    end

    // read data belongs to entry pos_reg unless the last edge moved the front pointer
    assign rd_addr  = slot_wrap({1'b0, front_reg} + {1'b0, pos_next});
    assign prev_sum = {1'b0, front_reg} + {1'b0, pos_reg} - 1'b1;
    assign wr_addr  = cmd.do_insert ? front_dec : slot_wrap(prev_sum);
    assign wr_en    = cmd.do_insert | cmd.shift_wr;
    assign wr_data  = cmd.do_insert ? in_value : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        count_next = count_reg;
        front_next = front_reg;
        if (cmd.do_clear) begin
            count_next = '0;
            front_next = '0;
        end else if (cmd.do_insert) begin
            count_next = count_reg + 1'b1;
            front_next = front_dec;
        end else if (cmd.dec_count) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        case (cmd.res_sel)
            SEL_IN:  res_data = in_value;
            SEL_VAL: res_data = value_reg;
            SEL_MEM: res_data = rd_data_reg;
            default: res_data = value_reg;
        endcase
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CNT_W'(CAPACITY));
    assign sts.match    = (rd_data_reg == value_reg);
    assign sts.at_last  = ((CNT_W'(pos_reg) + 1'b1) == count_reg);

    always_comb begin
        if (cmd.load_res) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            front_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            front_reg     <= front_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_value) begin
            value_reg <= in_value;
        end
        if (cmd.load_res) begin
            out_data_reg   <= res_data;
            out_status_reg <= cmd.res_status;
            out_last_reg   <= cmd.res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/circular_list_store.sv
`timescale 1ns / 1ps
// top level of the circular list store: sequencer, datapath and checks
//
//  channel | direction | tdata            | tuser          | tlast
//  s_      | in        | [31:0] value     | [1:0] action   | -
//  m_      | out       | [31:0] data      | [2:0] status   | last
//
// insert, clear and requests on an empty store are answered straight from the idle state
// delete searches entry by entry from the front for the value, then moves each later entry
// down one slot to close the gap; no match up to the tail gives not-found
// traverse gives the entries from the front, one word per cycle out of the entry ram
// while the output is free; its single read port walks the ring one slot per cycle
// synchronous reset empties the store, the ram itself is not cleared
// a stalled output holds a traverse in place and holds the final word of a delete;
// a new request is taken once idle with the result register free
module circular_list_store
    import cls_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [1:0]               s_tuser,   // [1:0] action
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [DATA_W-1:0] m_tdata,   // [31:0] data
    output logic [2:0]               m_tuser,   // [2:0] status
    output logic                     m_tlast
);

    cls_cmd_t cmd;
    cls_sts_t sts;

    cls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    cls_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a request is only taken when the result register can take its word
    a_accept_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (!m_tvalid || m_tready))
        else $error("request accepted while result register blocked");

    // every status word other than a traverse entry ends its request
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_ENTRY)) |-> m_tlast)
        else $error("single-word result without last");

    // store cannot be full and empty at once
    a_count_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sts.full && sts.empty))
        else $error("count inconsistent");

    // no ring moves while a new request can be taken
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!cmd.shift_wr && !cmd.pos_inc))
        else $error("walk activity while idle");

endmodule
